[rtl/aes_ctr_pkg.sv]
// shared types, tables and round functions for the aes-128 counter payload core
package aes_ctr_pkg;

   localparam int unsigned BLOCK_BYTES = 16;
   localparam int unsigned NUM_ROUNDS  = 10;
   localparam int unsigned CNT_W       = 5;

   localparam logic [7:0] CTR_LEAD = 8'h01;
   localparam logic [7:0] CTR_INIT = 8'h01;
   localparam logic [7:0] BYTE_MAX = 8'hFF;

   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef logic [127:0] block_type;

   // per-block control carried down the round pipeline
   typedef struct packed {
      logic        first;
      logic        err;
      logic [15:0] mask;
      block_type   data;
   } side_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   typedef logic [7:0] rcon_table_type [NUM_ROUNDS];
   localparam rcon_table_type RCON = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // byte i of a block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned i);
      get_byte = b[127 - 8*i -: 8];
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // next round key from the current one
   function automatic block_type next_key(input block_type k, input int unsigned rnd);
      logic [31:0] w0, w1, w2, w3, t;
      begin
         w0 = k[127:96];
         w1 = k[95:64];
         w2 = k[63:32];
         w3 = k[31:0];
         t  = {SBOX[w3[23:16]] ^ RCON[rnd], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
         w0 = w0 ^ t;
         w1 = w1 ^ w0;
         w2 = w2 ^ w1;
         w3 = w3 ^ w2;
         next_key = {w0, w1, w2, w3};
      end
   endfunction

   // one cipher round: sub bytes, shift rows, optional mix columns, add key
   function automatic block_type enc_round(input block_type s, input block_type k,
                                           input logic last);
      block_type t, m;
      logic [7:0] a0, a1, a2, a3, al;
      begin
         t = '0;
         m = '0;
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
            end
         end
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4*c);
            a1 = get_byte(t, 4*c + 1);
            a2 = get_byte(t, 4*c + 2);
            a3 = get_byte(t, 4*c + 3);
            al = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 8*(4*c)     -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
            m[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
            m[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
            m[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
         end
         enc_round = (last ? t : m) ^ k;
      end
   endfunction

endpackage

[rtl/aes128_counter_payload_encrypt_core.sv]
// aes-128 counter payload core: context memory, unrolled round pipeline, output skid
// stages, in order: request capture, whitening, ten round stages, output register;
// throughput: one transaction per cycle while the skid stage is empty, set by the rounds
// the message context (address, type, frame count, block counter) sits in a one-entry memory
// read through a register, with forwarding from blocks still in flight
// reset: synchronous, clears pipeline valids and the context to counter one and zero fields
// keys reset to zero; the round key schedule follows a key write one stage per cycle
module aes128_counter_payload_encrypt_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_block,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic [4:0]  req_valid_bytes,
   input  logic [31:0] req_dev_address,
   input  logic [7:0]  req_frame_type,
   input  logic [7:0]  req_frame_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   output logic        rsp_error,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_ctr_pkg::*;

   localparam int unsigned STAGES = NUM_ROUNDS + 2;
   localparam int unsigned CTX_W  = 56;

   // key registers and round key schedule
   logic [63:0] key_high_ff, key_low_ff;
   block_type   rkey [NUM_ROUNDS + 1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rkey[0] <= {key_high_ff, key_low_ff};
   end

   for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_ks
      always_ff @(posedge clock) begin
         rkey[g] <= next_key(rkey[g-1], g - 1);
      end
   end

   // pipeline flow: whole pipe advances unless the skid stage is full
   logic skid_full_ff;
   logic advance;
   assign advance   = !skid_full_ff;
   assign req_stall = skid_full_ff;
   logic take;
   assign take = req_valid && !req_stall;

   // context memory, single entry: {address, type, fcnt, counter}
   logic [CTX_W-1:0] ctx_mem [1];
   logic [CTX_W-1:0] ctx_rd_ff;
   logic             ctx_init_ff;
   logic [CTX_W-1:0] ctx_wr_in;
   logic             ctx_we;

   // stage 0: request capture and context read
   logic        s0_valid_ff, s0_first_ff;
   block_type   s0_data_ff;
   logic [4:0]  s0_cnt_ff;
   logic [47:0] s0_fields_ff;
   logic [CTX_W-1:0] fwd_ff;
   logic        fwd_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_first_ff  <= req_first_block;
         s0_data_ff   <= {req_data_high, req_data_low};
         s0_cnt_ff    <= req_valid_bytes;
         s0_fields_ff <= {req_dev_address, req_frame_type, req_frame_count};
      end
   end

   // registered memory read; last write forwarded when it lands the same cycle as the read
   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[0] <= ctx_wr_in;
      end
      ctx_rd_ff <= ctx_mem[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_init_ff <= 1'b1;
         fwd_use_ff  <= 1'b0;
      end else begin
         if (ctx_we) begin
            ctx_init_ff <= 1'b0;
         end
         fwd_use_ff <= ctx_we;
      end
      if (ctx_we) begin
         fwd_ff <= ctx_wr_in;
      end
   end

   // current context seen by stage 0
   logic [CTX_W-1:0] ctx_cur;
   always_comb begin
      if (fwd_use_ff) begin
         ctx_cur = fwd_ff;
      end else if (ctx_init_ff) begin
         ctx_cur = {48'h0, CTR_INIT};
      end else begin
         ctx_cur = ctx_rd_ff;
      end
   end

   // build the cipher input and the new context
   logic      s0_full;
   block_type cipher_in;
   logic [15:0] mask;
   logic [7:0] ctr_use;
   logic [31:0] adr;
   always_comb begin
      s0_full = (s0_cnt_ff >= CNT_W'(BLOCK_BYTES));
      adr     = ctx_cur[55:24];
      ctr_use = s0_first_ff ? CTR_INIT : ctx_cur[7:0];
      if (s0_first_ff) begin
         cipher_in = s0_data_ff;
      end else begin
         cipher_in = {CTR_LEAD, 32'h0, ctx_cur[23:16], adr[7:0], adr[15:8], adr[23:16],
                      adr[31:24], ctx_cur[15:8], 32'h0, ctx_cur[7:0]};
      end
      for (int i = 0; i < 16; i++) begin
         mask[15 - i] = s0_full || (CNT_W'(i) < s0_cnt_ff);
      end
      // a first block restarts the counter, so the next later block uses counter one
      if (s0_first_ff) begin
         ctx_wr_in = {s0_fields_ff, CTR_INIT};
      end else begin
         ctx_wr_in = {ctx_cur[55:8], 8'((ctr_use + 8'h01) & BYTE_MAX)};
      end
      ctx_we = s0_valid_ff && advance;
   end

   // round pipeline: stage 1 whitening, stages 2..11 rounds
   logic      pv_ff [1:STAGES-1];
   block_type st_ff [1:STAGES-1];
   side_type  sd_ff [1:STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff[1] <= 1'b0;
      end else if (advance) begin
         pv_ff[1] <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[1]       <= cipher_in ^ rkey[0];
         sd_ff[1].first <= s0_first_ff;
         sd_ff[1].err   <= s0_first_ff && !s0_full;
         sd_ff[1].mask  <= mask;
         sd_ff[1].data  <= s0_data_ff;
      end
   end

   for (genvar g = 2; g < STAGES; g++) begin : g_rnd
      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[g] <= 1'b0;
         end else if (advance) begin
            pv_ff[g] <= pv_ff[g-1];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            st_ff[g] <= enc_round(st_ff[g-1], rkey[g-1], (g - 1) == NUM_ROUNDS);
            sd_ff[g] <= sd_ff[g-1];
         end
      end
   end

   // result select
   block_type res;
   side_type  last;
   always_comb begin
      last = sd_ff[STAGES-1];
      if (last.first) begin
         res = last.err ? last.data : st_ff[STAGES-1];
      end else begin
         for (int i = 0; i < 16; i++) begin
            res[127 - 8*i -: 8] = last.mask[15 - i] ?
               (get_byte(last.data, i) ^ get_byte(st_ff[STAGES-1], i)) : get_byte(last.data, i);
         end
      end
   end

   // output register with skid stage
   logic      out_valid_ff;
   block_type out_data_ff, skid_data_ff;
   logic      out_err_ff, skid_err_ff;
   logic      out_free;
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= skid_full_ff || (pv_ff[STAGES-1] && advance);
            skid_full_ff <= 1'b0;
         end else if (pv_ff[STAGES-1] && advance) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_full_ff ? skid_data_ff : res;
         out_err_ff  <= skid_full_ff ? skid_err_ff : last.err;
      end else if (advance) begin
         skid_data_ff <= res;
         skid_err_ff  <= last.err;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_high = out_data_ff[127:64];
   assign rsp_out_low  = out_data_ff[63:0];
   assign rsp_error    = out_err_ff;

endmodule

[rtl/aes_ctr_checker.sv]
// port-level checker for the aes-128 counter payload core, bound to the top level
module aes_ctr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_out_high,
   input logic        rsp_error
);
   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_high) && $stable(rsp_error))
      else $error("response changed under stall");

   // no response right after reset
   a_rst_idle: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

   // request stall only raised while output is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without output back-pressure");

   // stall released once output drains
   a_stall_free: assert property (@(posedge clock) disable iff (reset)
      req_stall && !rsp_stall |=> !req_stall)
      else $error("request stall held after output drained");
endmodule

bind aes128_counter_payload_encrypt_core aes_ctr_checker u_aes_ctr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_high (rsp_out_high),
   .rsp_error    (rsp_error)
);

[tb/aes_ctr_payload_checker.sv]
// checker for the aes-128 counter payload core: predicts each response and compares
`timescale 1ns / 1ps

module aes_ctr_payload_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_first_block,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic [4:0]  req_valid_bytes,
   input  logic [31:0] req_dev_address,
   input  logic [7:0]  req_frame_type,
   input  logic [7:0]  req_frame_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_out_high,
   input  logic [63:0] rsp_out_low,
   input  logic        rsp_error,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending
);
   import aes_ctr_pkg::*;

   typedef struct packed {
      logic [63:0] out_high;
      logic [63:0] out_low;
      logic        error;
   } cipher_result_type;

   logic [7:0]        sub_byte [256];
   logic [127:0]      cipher_key;
   logic [7:0]        block_ctr;
   logic [31:0]       msg_address;
   logic [7:0]        msg_type;
   logic [7:0]        msg_frame_count;
   cipher_result_type expected_results [$];
   int                mismatches;
   int                queued = 0;

   assign fail_count = mismatches;
   assign pending    = queued;

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ a;
         a = xtime(a);
      end
      return p;
   endfunction

   // substitution table built from the field inverse and the affine map
   initial begin
      logic [7:0] inv, v;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         for (int y = 1; y < 256; y++) begin
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         end
         v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sub_byte[x] = v;
      end
   end

   // full aes-128 encryption of one block, byte 0 in the top bits
   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] plain);
      logic [7:0]   rk [176];
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a, b, d, e, tmp, rc, a0, a1, a2, a3, al;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127 - 8*i -: 8];
         s[i]  = plain[127 - 8*i -: 8] ^ rk[i];
      end
      rc = 8'h01;
      for (int i = 16; i < 176; i += 4) begin
         a = rk[i-4]; b = rk[i-3]; d = rk[i-2]; e = rk[i-1];
         if (i % 16 == 0) begin
            tmp = a;
            a   = sub_byte[b] ^ rc;
            b   = sub_byte[d];
            d   = sub_byte[e];
            e   = sub_byte[tmp];
            rc  = xtime(rc);
         end
         rk[i]   = rk[i-16] ^ a;
         rk[i+1] = rk[i-15] ^ b;
         rk[i+2] = rk[i-14] ^ d;
         rk[i+3] = rk[i-13] ^ e;
      end
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r + 4*c] = sub_byte[s[r + 4*((c + r) % 4)]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (rnd < 10) begin
               al = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
               s[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
               s[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
               s[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end else begin
               s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*rnd + i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // predict on every accepted request, compare on every accepted response
   always @(posedge clock) begin
      logic [127:0]      data, ctr_block, stream;
      int unsigned       count;
      cipher_result_type want;
      if (reset) begin
         cipher_key      = '0;
         block_ctr       = 8'h01;
         msg_address     = '0;
         msg_type        = '0;
         msg_frame_count = '0;
         expected_results.delete();
         mismatches      = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_KEY_HIGH) cipher_key[127:64] = csr_data;
            else cipher_key[63:0] = csr_data;
         end
         if (req_valid && !req_stall) begin
            data  = {req_data_high, req_data_low};
            count = (req_valid_bytes > 16) ? 16 : req_valid_bytes;
            if (req_first_block) begin
               msg_address     = req_dev_address;
               msg_type        = req_frame_type;
               msg_frame_count = req_frame_count;
               block_ctr       = 8'h01;
               if (count < 16) want = {data, 1'b1};
               else want = {aes_encrypt(cipher_key, data), 1'b0};
            end else begin
               ctr_block = {8'h01, 32'h0, msg_type, msg_address[7:0], msg_address[15:8],
                            msg_address[23:16], msg_address[31:24], msg_frame_count,
                            32'h0, block_ctr};
               stream = aes_encrypt(cipher_key, ctr_block);
               for (int i = 0; i < 16; i++)
                  if (i < count) data[127 - 8*i -: 8] ^= stream[127 - 8*i -: 8];
               want = {data, 1'b0};
               block_ctr = block_ctr + 8'h01;
            end
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction, out_high", rsp_out_high, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_high !== want.out_high)
                  report_mismatch("out_high", rsp_out_high, want.out_high);
               if (rsp_out_low !== want.out_low)
                  report_mismatch("out_low", rsp_out_low, want.out_low);
               if (rsp_error !== want.error)
                  report_mismatch("error", rsp_error, want.error);
            end
         end
      end
      queued = expected_results.size();
   end

endmodule

[tb/aes128_counter_payload_encrypt_core_test.sv]
// top of the testbench for the aes-128 counter payload core: stimulus and verdict
`timescale 1ns / 1ps

module aes128_counter_payload_encrypt_core_test;
   import aes_ctr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_first_block = 1'b0;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low = '0;
   logic [4:0]  req_valid_bytes = '0;
   logic [31:0] req_dev_address = '0;
   logic [7:0]  req_frame_type = '0;
   logic [7:0]  req_frame_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic        rsp_error;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;

   aes128_counter_payload_encrypt_core dut (.*);

   aes_ctr_payload_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random
   always @(negedge clock) rsp_stall = ($urandom_range(99) < rsp_stall_pct);

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic write_key(input logic [63:0] high, input logic [63:0] low);
      @(negedge clock);
      csr_write = 1'b1; csr_index = CSR_KEY_HIGH; csr_data = high;
      @(negedge clock);
      csr_index = CSR_KEY_LOW; csr_data = low;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic send_block(input logic first, input logic [127:0] data,
                             input logic [4:0] nbytes, input logic [31:0] addr,
                             input logic [7:0] ftype, input logic [7:0] fcount);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_first_block = first;
      {req_data_high, req_data_low} = data;
      req_valid_bytes = nbytes;
      req_dev_address = addr;
      req_frame_type  = ftype;
      req_frame_count = fcount;
      do @(posedge clock); while (req_stall);
   endtask

   // lower valid and wait for every response, then let the pipeline settle
   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [127:0] rand_block();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [4:0] rand_count();
      if ($urandom_range(3) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(1, 16));
   endfunction

   // one message: mostly a full first block, then later blocks with random content
   task automatic send_message(input int blocks);
      logic [31:0] addr;
      logic [7:0]  ftype, fcount;
      addr = $urandom; ftype = 8'($urandom); fcount = 8'($urandom);
      send_block(1'b1, rand_block(), ($urandom_range(9) == 0) ? rand_count() : 5'd16,
                 addr, ftype, fcount);
      for (int i = 0; i < blocks; i++)
         send_block(1'b0, rand_block(), rand_count(), $urandom, 8'($urandom), 8'($urandom));
   endtask

   task automatic random_phase(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(9) == 0) begin
            // noise: a stray block of either kind
            send_block(1'($urandom_range(1)), rand_block(), 5'($urandom_range(0, 31)),
                       $urandom, 8'($urandom), 8'($urandom));
            sent++;
         end else begin
            len = $urandom_range(0, 12);
            send_message(len);
            sent += len + 1;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: later block straight after reset, then field extremes
      send_block(1'b0, {128{1'b1}}, 5'd16, '0, '0, '0);
      drain();
      write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(1'b1, 128'h00112233445566778899aabbccddeeff, 5'd16, '0, '0, '0);
      send_block(1'b0, '0, 5'd1, '0, '0, '0);
      send_block(1'b0, {128{1'b1}}, 5'd15, '1, '1, '1);
      send_block(1'b0, '0, 5'd16, '0, '0, '0);
      send_block(1'b0, rand_block(), 5'd17, '0, '0, '0);
      send_block(1'b0, rand_block(), 5'd31, '0, '0, '0);
      send_block(1'b0, rand_block(), 5'd0, '0, '0, '0);
      send_block(1'b1, {128{1'b1}}, 5'd31, '1, '1, '1);
      send_block(1'b0, {128{1'b1}}, 5'd16, '0, '0, '0);
      send_block(1'b1, rand_block(), 5'd1, 32'h12345678, 8'h5a, 8'ha5);
      send_block(1'b0, rand_block(), 5'd16, '0, '0, '0);
      send_block(1'b1, rand_block(), 5'd15, '1, '0, '1);
      send_block(1'b0, rand_block(), 5'd8, '0, '0, '0);
      send_block(1'b1, rand_block(), 5'd0, '0, '1, '0);
      send_block(1'b0, rand_block(), 5'd16, '0, '0, '0);
      drain();

      // counter wrap past 255 blocks in one message, no idling
      write_key('1, '1);
      send_message(260);
      drain();

      write_key('0, '0);
      send_idle_pct = 66; rsp_stall_pct = 0;
      random_phase(300);
      drain();

      write_key({$urandom, $urandom}, {$urandom, $urandom});
      send_idle_pct = 0; rsp_stall_pct = 66;
      random_phase(300);
      drain();

      write_key({$urandom, $urandom}, {$urandom, $urandom});
      send_idle_pct = 28; rsp_stall_pct = 28;
      random_phase(300);
      drain();

      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
